[rtl/bud_pkg.sv]
// Shared types and constants for the byte unstuffing deframer.
package bud_pkg;

  localparam int unsigned DEF_FRAME_CAPACITY = 256;

  localparam logic [7:0] RST_FRAME_BEGIN   = 8'd192;
  localparam logic [7:0] RST_ESCAPE        = 8'd219;
  localparam logic [7:0] RST_ESC_BEGIN     = 8'd220;
  localparam logic [7:0] RST_ESC_ESCAPE    = 8'd221;
  localparam logic       RST_HUNT_ENABLE   = 1'b1;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // Register map, word index (byte address divided by four).
  typedef enum logic [2:0] {
    REG_FRAME_BEGIN = 3'd0,
    REG_ESCAPE      = 3'd1,
    REG_ESC_BEGIN   = 3'd2,
    REG_ESC_ESCAPE  = 3'd3,
    REG_HUNT_ENABLE = 3'd4
  } reg_idx_t;

  // Request codes carried in req_type.
  typedef enum logic {
    REQ_BYTE    = 1'b0,
    REQ_RESTART = 1'b1
  } req_t;

  // One queued result beat.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] index;
    logic       last;
  } result_t;

endpackage

[rtl/byte_unstuffing_deframer.sv]
// Byte unstuffing deframer: hunt, escape removal and frame length limit.
//
// Usage: line bytes enter on the input channel (in_valid/in_ready) with
// req_type selecting a line byte or a restart request. Unstuffed frame bytes
// leave on the output channel (out_valid/out_ready), each with its position in
// the frame (modulo 256) and a last_of_run flag on the final beat caused by
// one input beat. A beat may cause zero, one or two output beats.
// The escape decision and state update are made in the cycle the input beat
// is accepted; its results are written into a four-entry result queue, from
// which the output port presents them in order.
// in_ready is high while the queue holds at most two results, so one input
// beat can be taken every cycle as long as the receiver keeps up; the output
// port drains one beat per cycle, which bounds the sustained rate when many
// escape pairs expand to two bytes.
// When the receiver stalls, results wait in the queue and input beats keep
// being taken until the queue could no longer hold a worst-case expansion.
// The user must write configuration over the APB-style port only while the
// block is idle; the block itself does not enforce this. Synchronous reset
// empties the queue, clears the escape flag and the frame count, restores the
// register defaults, and starts hunting for a frame-begin byte.
module byte_unstuffing_deframer #(
  parameter int unsigned FRAME_CAPACITY = bud_pkg::DEF_FRAME_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bud_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bud_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bud_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [7:0]                     in_byte,
  // Output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic [7:0]                     out_index,
  output logic                           last_of_run
);
  import bud_pkg::*;

  localparam int unsigned CNT_W   = $clog2(FRAME_CAPACITY + 1);
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned PTR_W   = 2;

  localparam logic [CNT_W-1:0] CAP       = CNT_W'(FRAME_CAPACITY);
  localparam logic [CNT_W-1:0] CAP_LESS1 = CNT_W'(FRAME_CAPACITY - 1);

  // Configuration registers.
  logic [7:0] frame_begin_code;
  logic [7:0] escape_code;
  logic [7:0] escaped_begin_code;
  logic [7:0] escaped_escape_code;
  logic       hunt_enable;

  // Deframer state.
  logic             hunting, hunting_next;
  logic             escape_pending, escape_pending_next;
  logic [CNT_W-1:0] frame_count, frame_count_next;

  // Result queue.
  result_t          q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   q_count, q_count_next;

  logic       cfg_wr;
  reg_idx_t   cfg_idx;
  logic       in_fire, out_fire;
  logic       is_line, pass_hunt, room, room2, active;
  logic [1:0] n_res;
  logic [7:0] res0_data, res1_data;
  logic [CNT_W+7:0] cnt_ext0, cnt_ext1;
  logic [CNT_W-1:0] cnt_plus1;
  result_t    res0, res1;

  // ---------------------------------------------------------------------
  // Configuration port: zero-wait writes, reads return register contents.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_begin_code    <= RST_FRAME_BEGIN;
      escape_code         <= RST_ESCAPE;
      escaped_begin_code  <= RST_ESC_BEGIN;
      escaped_escape_code <= RST_ESC_ESCAPE;
      hunt_enable         <= RST_HUNT_ENABLE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_BEGIN: frame_begin_code    <= pwdata[7:0];
        REG_ESCAPE:      escape_code         <= pwdata[7:0];
        REG_ESC_BEGIN:   escaped_begin_code  <= pwdata[7:0];
        REG_ESC_ESCAPE:  escaped_escape_code <= pwdata[7:0];
        REG_HUNT_ENABLE: hunt_enable         <= pwdata[0];
        default: ;  // Addresses beyond the map are ignored.
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_BEGIN: prdata = {24'b0, frame_begin_code};
      REG_ESCAPE:      prdata = {24'b0, escape_code};
      REG_ESC_BEGIN:   prdata = {24'b0, escaped_begin_code};
      REG_ESC_ESCAPE:  prdata = {24'b0, escaped_escape_code};
      REG_HUNT_ENABLE: prdata = {31'b0, hunt_enable};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Unstuffing decision for the beat being accepted.
  // ---------------------------------------------------------------------
  // Accept only while a two-result expansion is guaranteed to fit.
  assign in_ready = (q_count <= (PTR_W + 1)'(Q_DEPTH - 2));
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  assign is_line   = in_fire && (req_t'(req_type) == REQ_BYTE);
  assign pass_hunt = !hunting || (in_byte == frame_begin_code);
  assign room      = frame_count < CAP;
  assign room2     = frame_count < CAP_LESS1;
  assign active    = is_line && pass_hunt && room;
  assign cnt_plus1 = frame_count + CNT_W'(1);

  // The frame position is reported modulo 256 whatever the counter width.
  assign cnt_ext0 = {8'b0, frame_count};
  assign cnt_ext1 = {8'b0, cnt_plus1};

  always_comb begin
    n_res               = 2'd0;
    res0_data           = in_byte;
    res1_data           = in_byte;
    escape_pending_next = escape_pending;
    if (active) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (in_byte == escaped_begin_code) begin
          res0_data = frame_begin_code;
          n_res     = 2'd1;
        end else begin
          // An unknown second byte keeps both bytes, space permitting.
          res0_data = escape_code;
          n_res     = (in_byte != escaped_escape_code && room2) ? 2'd2 : 2'd1;
        end
      end else if (in_byte == escape_code) begin
        escape_pending_next = 1'b1;
      end else begin
        n_res = 2'd1;
      end
    end
  end

  always_comb begin
    res0.data  = res0_data;
    res0.index = cnt_ext0[7:0];
    res0.last  = (n_res == 2'd1);
    res1.data  = res1_data;
    res1.index = cnt_ext1[7:0];
    res1.last  = 1'b1;
  end

  always_comb begin
    hunting_next     = hunting;
    frame_count_next = frame_count + CNT_W'(n_res);
    if (in_fire && req_t'(req_type) == REQ_RESTART) begin
      hunting_next     = hunt_enable;
      frame_count_next = '0;
    end else if (is_line && hunting && in_byte == frame_begin_code) begin
      hunting_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting        <= RST_HUNT_ENABLE;
      escape_pending <= 1'b0;
      frame_count    <= '0;
    end else begin
      hunting        <= hunting_next;
      frame_count    <= frame_count_next;
      if (in_fire && req_t'(req_type) == REQ_RESTART) begin
        escape_pending <= 1'b0;
      end else begin
        escape_pending <= escape_pending_next;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result queue: up to two pushes and one pop per cycle.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      q[wr_ptr] <= res0;
    end
    if (n_res == 2'd2) begin
      q[wr_ptr + PTR_W'(1)] <= res1;
    end
  end

  assign q_count_next = q_count + (PTR_W + 1)'(n_res) - (PTR_W + 1)'(out_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + PTR_W'(n_res);
      rd_ptr  <= rd_ptr + PTR_W'(out_fire);
      q_count <= q_count_next;
    end
  end

  assign out_valid   = (q_count != '0);
  assign out_byte    = q[rd_ptr].data;
  assign out_index   = q[rd_ptr].index;
  assign last_of_run = q[rd_ptr].last;

`ifndef NO_ASSERTIONS
  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    q_count <= (PTR_W + 1)'(Q_DEPTH))
    else $error("result queue overflow");

  a_frame_bound : assert property (@(posedge clk) disable iff (rst)
    frame_count <= CAP)
    else $error("frame count beyond capacity");

  a_hunt_empty : assert property (@(posedge clk) disable iff (rst)
    hunting |-> (frame_count == '0 && !escape_pending))
    else $error("frame state while hunting");

  a_restart_clears : assert property (@(posedge clk) disable iff (rst)
    (in_fire && req_type == REQ_RESTART) |=> (frame_count == '0 && !escape_pending))
    else $error("restart did not clear the frame");
`endif

endmodule
